@@ rtl/ogrc_pkg.sv @@
// Package for the occupancy grid ray caster.
// Field widths, cell codes, register indexes and default grid size.
// No dependencies.
package ogrc_pkg;

    localparam int POS_W   = 24;  // millimetre positions
    localparam int CPM_W   = 16;  // Q16 cells per millimetre
    localparam int DIM_W   = 9;   // grid_width / grid_height
    localparam int CELL_W  = 2;   // one grid cell
    localparam int RC_W    = 8;   // read_col / read_row
    localparam int FREED_W = 9;
    localparam int IDX_W   = 3;   // configuration register index

    localparam int DIFF_W  = POS_W + 1;          // position minus origin
    localparam int PROD_W  = DIFF_W + CPM_W;     // magnitude times scale
    localparam int Q_W     = POS_W;              // quantized magnitude
    localparam int COORD_W = 27;                 // signed cell coordinate along the ray
    localparam int ERR_W   = COORD_W + 2;        // Bresenham error term

    localparam int DEF_GRID_COLS = 256;
    localparam int DEF_GRID_ROWS = 256;

    localparam logic [FREED_W-1:0] FREED_MAX = '1;

    localparam logic [CELL_W-1:0] CELL_UNKNOWN  = 2'd0;
    localparam logic [CELL_W-1:0] CELL_FREE     = 2'd1;
    localparam logic [CELL_W-1:0] CELL_OCCUPIED = 2'd2;

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_READ   = 1'b1;

    localparam logic [POS_W-1:0] RST_ORIGIN       = '0;
    localparam logic [POS_W-1:0] RST_SENSOR       = '0;
    localparam logic [CPM_W-1:0] RST_CELLS_PER_MM = 16'd1311;
    localparam logic [DIM_W-1:0] RST_GRID_DIM     = 9'd256;

    typedef enum logic [IDX_W-1:0] {
        CFG_MAP_ORIGIN_X = 3'd0,
        CFG_MAP_ORIGIN_Y = 3'd1,
        CFG_SENSOR_X     = 3'd2,
        CFG_SENSOR_Y     = 3'd3,
        CFG_CELLS_PER_MM = 3'd4,
        CFG_GRID_WIDTH   = 3'd5,
        CFG_GRID_HEIGHT  = 3'd6
    } t_cfg_idx;

endpackage

@@ rtl/occupancy_grid_ray_caster.sv @@
// Occupancy grid ray caster, top level.
// Uses ogrc_pkg and the grid memory ogrc_ram.
//
// The grid is GRID_COLS x GRID_ROWS cells of 2 bits (unknown, free, occupied) in one RAM
// addressed {col, row}. After reset the block sweeps the whole RAM to unknown, one entry a
// cycle; the input channel stalls during the sweep, configuration writes are taken
// throughout. One item is worked on at a time and the input stalls until it is finished.
// A read item passes ST_READ_RD, ST_READ_WAIT and ST_FINISH, skipping ST_READ_WAIT when
// the cell lies outside the grid in use. An insert item first quantizes the point and the
// sensor position with one shared 25x16 multiplier, in the states ST_Q_DIFF, ST_Q_MUL and
// ST_Q_STORE for each coordinate, then passes the setup states ST_SETUP_A and ST_SETUP_B,
// then walks the ray: each in-grid cell takes ST_WALK_RD (RAM read), then ST_WALK_CHK
// (check and write back on the single RAM port pair), each out-of-grid cell ST_WALK_RD
// only, and ST_FINISH hands the result over. That last state is held for as long as the
// previous result is still waiting and stalled. A ray is at most GRID_COLS+GRID_ROWS
// cells. The result sits in an output register; the next item is accepted while it
// waits to be taken.
module occupancy_grid_ray_caster #(
    parameter int GRID_COLS = ogrc_pkg::DEF_GRID_COLS,
    parameter int GRID_ROWS = ogrc_pkg::DEF_GRID_ROWS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // input channel
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic                             i_kind,
    input  logic signed [ogrc_pkg::POS_W-1:0] i_point_x,
    input  logic signed [ogrc_pkg::POS_W-1:0] i_point_y,
    input  logic [ogrc_pkg::RC_W-1:0]        i_read_col,
    input  logic [ogrc_pkg::RC_W-1:0]        i_read_row,
    // result channel
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [ogrc_pkg::CELL_W-1:0]      o_cell_state,
    output logic                             o_endpoint_inside,
    output logic [ogrc_pkg::FREED_W-1:0]     o_cells_freed,
    // configuration write channel
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [ogrc_pkg::IDX_W-1:0]       i_cfg_index,
    input  logic [ogrc_pkg::POS_W-1:0]       i_cfg_data
);

    localparam int CW        = $clog2(GRID_COLS);
    localparam int RW        = $clog2(GRID_ROWS);
    localparam int AW        = CW + RW;
    localparam int DEPTH     = 1 << AW;
    localparam int RAY_LIMIT = GRID_COLS + GRID_ROWS;
    localparam int SW        = $clog2(RAY_LIMIT + 1);
    localparam int SUM_W     = ogrc_pkg::COORD_W + 1;
    localparam int MAX_DIM   = (GRID_COLS > GRID_ROWS) ? GRID_COLS : GRID_ROWS;
    localparam int LIM_RAW   = $clog2(MAX_DIM + 1);
    localparam int LIM_W     = (LIM_RAW > ogrc_pkg::DIM_W) ? LIM_RAW : ogrc_pkg::DIM_W;

    localparam int COORD_W = ogrc_pkg::COORD_W;
    localparam int ERR_W   = ogrc_pkg::ERR_W;
    localparam int DIFF_W  = ogrc_pkg::DIFF_W;
    localparam int PROD_W  = ogrc_pkg::PROD_W;
    localparam int Q_W     = ogrc_pkg::Q_W;
    localparam int POS_W   = ogrc_pkg::POS_W;
    localparam int CELL_W  = ogrc_pkg::CELL_W;
    localparam int FREED_W = ogrc_pkg::FREED_W;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_Q_DIFF,
        ST_Q_MUL,
        ST_Q_STORE,
        ST_SETUP_A,
        ST_SETUP_B,
        ST_WALK_RD,
        ST_WALK_CHK,
        ST_READ_RD,
        ST_READ_WAIT,
        ST_FINISH
    } t_state;

    // configuration
    logic [POS_W-1:0]                 r_origin_x, r_origin_y, r_sensor_x, r_sensor_y;
    logic [ogrc_pkg::CPM_W-1:0]       r_cpm;
    logic [ogrc_pkg::DIM_W-1:0]       r_grid_width, r_grid_height;

    // sequencer and datapath
    t_state                           r_state;
    logic [AW-1:0]                    r_clr;
    logic [POS_W-1:0]                 r_pt_x, r_pt_y;
    logic [ogrc_pkg::RC_W-1:0]        r_rd_col, r_rd_row;
    logic [1:0]                       r_qi;
    logic [DIFF_W-1:0]                r_mag;
    logic                             r_neg;
    logic [PROD_W-1:0]                r_prod;
    logic signed [COORD_W-1:0]        r_x1, r_y1, r_x0, r_y0, r_x, r_y;
    logic [COORD_W-1:0]               r_dx, r_dy;
    logic                             r_sx_neg, r_sy_neg;
    logic signed [ERR_W-1:0]          r_err;
    logic [SW-1:0]                    r_steps;
    logic [CELL_W-1:0]                r_res_state;
    logic                             r_res_inside;
    logic [FREED_W-1:0]               r_res_freed;
    logic                             r_out_valid;
    logic [CELL_W-1:0]                r_out_state;
    logic                             r_out_inside;
    logic [FREED_W-1:0]               r_out_freed;

    // combinational
    logic [LIM_W-1:0]                 col_lim, row_lim, w_ext, h_ext;
    logic [POS_W-1:0]                 q_pos, q_org;
    logic [DIFF_W-1:0]                n_diff, n_mag;
    logic signed [COORD_W-1:0]        n_qext, n_cell;
    logic [COORD_W-1:0]               n_dx, n_dy;
    logic [SUM_W-1:0]                 n_sum;
    logic [SW-1:0]                    n_steps;
    logic                             err_pos;
    logic signed [ERR_W-1:0]          n_err;
    logic signed [COORD_W-1:0]        n_x, n_y;
    logic                             end_inside, walk_inside, read_inside;
    logic signed [COORD_W-1:0]        rd_col_c, rd_row_c;
    logic                             ram_we;
    logic [AW-1:0]                    ram_waddr, ram_raddr;
    logic [CELL_W-1:0]                ram_wdata, ram_rdata;

    function automatic logic f_inside(input logic signed [COORD_W-1:0] c,
                                      input logic [LIM_W-1:0] lim);
        logic [COORD_W-1:0] cu;
        cu = c;
        f_inside = !c[COORD_W-1] && (cu < COORD_W'(lim));
    endfunction

    function automatic logic [AW-1:0] f_addr(input logic signed [COORD_W-1:0] c,
                                             input logic signed [COORD_W-1:0] r);
        f_addr = {c[CW-1:0], r[RW-1:0]};
    endfunction

    // ---------------------------------------------------------------- config
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_x    <= ogrc_pkg::RST_ORIGIN;
            r_origin_y    <= ogrc_pkg::RST_ORIGIN;
            r_sensor_x    <= ogrc_pkg::RST_SENSOR;
            r_sensor_y    <= ogrc_pkg::RST_SENSOR;
            r_cpm         <= ogrc_pkg::RST_CELLS_PER_MM;
            r_grid_width  <= ogrc_pkg::RST_GRID_DIM;
            r_grid_height <= ogrc_pkg::RST_GRID_DIM;
        end else if (i_cfg_valid) begin
            unique case (ogrc_pkg::t_cfg_idx'(i_cfg_index))
                ogrc_pkg::CFG_MAP_ORIGIN_X: r_origin_x <= i_cfg_data;
                ogrc_pkg::CFG_MAP_ORIGIN_Y: r_origin_y <= i_cfg_data;
                ogrc_pkg::CFG_SENSOR_X:     r_sensor_x <= i_cfg_data;
                ogrc_pkg::CFG_SENSOR_Y:     r_sensor_y <= i_cfg_data;
                ogrc_pkg::CFG_CELLS_PER_MM: r_cpm <= i_cfg_data[ogrc_pkg::CPM_W-1:0];
                ogrc_pkg::CFG_GRID_WIDTH:   r_grid_width <= i_cfg_data[ogrc_pkg::DIM_W-1:0];
                ogrc_pkg::CFG_GRID_HEIGHT:  r_grid_height <= i_cfg_data[ogrc_pkg::DIM_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // grid in use, clipped to the physical grid
    always_comb begin
        w_ext   = LIM_W'(r_grid_width);
        h_ext   = LIM_W'(r_grid_height);
        col_lim = (w_ext > LIM_W'(GRID_COLS)) ? LIM_W'(GRID_COLS) : w_ext;
        row_lim = (h_ext > LIM_W'(GRID_ROWS)) ? LIM_W'(GRID_ROWS) : h_ext;
    end

    // ---------------------------------------------------------------- datapath
    always_comb begin
        // quantizer operand select: point x, point y, sensor x, sensor y
        case (r_qi)
            2'd0:    begin q_pos = r_pt_x;     q_org = r_origin_x; end
            2'd1:    begin q_pos = r_pt_y;     q_org = r_origin_y; end
            2'd2:    begin q_pos = r_sensor_x; q_org = r_origin_x; end
            default: begin q_pos = r_sensor_y; q_org = r_origin_y; end
        endcase
        n_diff = {q_pos[POS_W-1], q_pos} - {q_org[POS_W-1], q_org};
        n_mag  = n_diff[DIFF_W-1] ? -n_diff : n_diff;

        // truncate toward zero: scale the magnitude, then restore the sign
        n_qext = {{(COORD_W-Q_W){1'b0}}, r_prod[Q_W+15:16]};
        n_cell = r_neg ? -n_qext : n_qext;

        n_dx = (r_x1 > r_x0) ? COORD_W'(r_x1 - r_x0) : COORD_W'(r_x0 - r_x1);
        n_dy = (r_y1 > r_y0) ? COORD_W'(r_y1 - r_y0) : COORD_W'(r_y0 - r_y1);

        n_sum   = SUM_W'(r_dx) + SUM_W'(r_dy) + SUM_W'(1);
        n_steps = (n_sum > SUM_W'(RAY_LIMIT)) ? SW'(RAY_LIMIT) : n_sum[SW-1:0];

        err_pos = !r_err[ERR_W-1] && (r_err != '0);
        n_err   = err_pos ? r_err - ERR_W'({r_dy, 1'b0}) : r_err + ERR_W'({r_dx, 1'b0});
        n_x     = r_x;
        n_y     = r_y;
        if (err_pos) begin
            n_x = r_sx_neg ? r_x - COORD_W'(1) : r_x + COORD_W'(1);
        end else begin
            n_y = r_sy_neg ? r_y - COORD_W'(1) : r_y + COORD_W'(1);
        end

        rd_col_c    = COORD_W'(r_rd_col);
        rd_row_c    = COORD_W'(r_rd_row);
        end_inside  = f_inside(r_x1, col_lim) && f_inside(r_y1, row_lim);
        walk_inside = f_inside(r_x, col_lim) && f_inside(r_y, row_lim);
        read_inside = f_inside(rd_col_c, col_lim) && f_inside(rd_row_c, row_lim);
    end

    // grid memory port control
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = f_addr(r_x, r_y);
        ram_wdata = ogrc_pkg::CELL_FREE;
        ram_raddr = f_addr(r_x, r_y);
        unique case (r_state)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
                ram_wdata = ogrc_pkg::CELL_UNKNOWN;
            end
            ST_SETUP_A: begin
                ram_we    = end_inside;
                ram_waddr = f_addr(r_x1, r_y1);
                ram_wdata = ogrc_pkg::CELL_OCCUPIED;
            end
            ST_WALK_CHK: begin
                ram_we = (ram_rdata != ogrc_pkg::CELL_OCCUPIED);
            end
            ST_READ_RD: begin
                ram_raddr = f_addr(rd_col_c, rd_row_c);
            end
            default: begin
            end
        endcase
    end

    ogrc_ram #(
        .WIDTH (CELL_W),
        .DEPTH (DEPTH)
    ) u_grid (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // ---------------------------------------------------------------- sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr       <= '0;
            r_qi        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // in ST_FINISH the hand-over below owns the valid flag
            if (r_out_valid && !i_out_stall && r_state != ST_FINISH) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_CLEAR: begin
                    r_clr <= r_clr + AW'(1);
                    if (r_clr == '1) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_pt_x       <= i_point_x;
                        r_pt_y       <= i_point_y;
                        r_rd_col     <= i_read_col;
                        r_rd_row     <= i_read_row;
                        r_qi         <= '0;
                        r_res_state  <= ogrc_pkg::CELL_UNKNOWN;
                        r_res_inside <= 1'b0;
                        r_res_freed  <= '0;
                        r_state      <= (i_kind == ogrc_pkg::KIND_READ) ? ST_READ_RD
                                                                         : ST_Q_DIFF;
                    end
                end
                ST_Q_DIFF: begin
                    r_mag   <= n_mag;
                    r_neg   <= n_diff[DIFF_W-1];
                    r_state <= ST_Q_MUL;
                end
                ST_Q_MUL: begin
                    r_prod  <= r_mag * r_cpm;
                    r_state <= ST_Q_STORE;
                end
                ST_Q_STORE: begin
                    case (r_qi)
                        2'd0:    r_x1 <= n_cell;
                        2'd1:    r_y1 <= n_cell;
                        2'd2:    r_x0 <= n_cell;
                        default: r_y0 <= n_cell;
                    endcase
                    r_qi    <= r_qi + 2'd1;
                    r_state <= (r_qi == 2'd3) ? ST_SETUP_A : ST_Q_DIFF;
                end
                ST_SETUP_A: begin
                    // endpoint is written to the grid in this state when it lies inside the grid in use
                    r_res_inside <= end_inside;
                    r_dx         <= n_dx;
                    r_dy         <= n_dy;
                    r_sx_neg     <= !(r_x0 < r_x1);
                    r_sy_neg     <= !(r_y0 < r_y1);
                    r_state      <= ST_SETUP_B;
                end
                ST_SETUP_B: begin
                    r_err   <= ERR_W'(r_dx) - ERR_W'(r_dy);
                    r_steps <= n_steps;
                    r_x     <= r_x0;
                    r_y     <= r_y0;
                    r_state <= ST_WALK_RD;
                end
                ST_WALK_RD: begin
                    if (walk_inside) begin
                        r_state <= ST_WALK_CHK;
                    end else begin
                        r_err   <= n_err;
                        r_x     <= n_x;
                        r_y     <= n_y;
                        r_steps <= r_steps - SW'(1);
                        r_state <= (r_steps == SW'(1)) ? ST_FINISH : ST_WALK_RD;
                    end
                end
                ST_WALK_CHK: begin
                    if (ram_rdata == ogrc_pkg::CELL_UNKNOWN &&
                        r_res_freed != ogrc_pkg::FREED_MAX) begin
                        r_res_freed <= r_res_freed + FREED_W'(1);
                    end
                    r_err   <= n_err;
                    r_x     <= n_x;
                    r_y     <= n_y;
                    r_steps <= r_steps - SW'(1);
                    r_state <= (r_steps == SW'(1)) ? ST_FINISH : ST_WALK_RD;
                end
                ST_READ_RD: begin
                    r_state <= read_inside ? ST_READ_WAIT : ST_FINISH;
                end
                ST_READ_WAIT: begin
                    r_res_state <= ram_rdata;
                    r_state     <= ST_FINISH;
                end
                ST_FINISH: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid  <= 1'b1;
                        r_out_state  <= r_res_state;
                        r_out_inside <= r_res_inside;
                        r_out_freed  <= r_res_freed;
                        r_state      <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall        = (r_state != ST_IDLE);
    assign o_out_valid       = r_out_valid;
    assign o_cell_state      = r_out_state;
    assign o_endpoint_inside = r_out_inside;
    assign o_cells_freed     = r_out_freed;

endmodule

@@ rtl/ogrc_ram.sv @@
// Generic single-clock RAM: one write port, one read port, registered read data.
// No dependencies.
module ogrc_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
